### sv/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

   localparam int MaxBlocks   = 64;
   localparam int HeaderBytes = 16;
   localparam int CountW      = $clog2(MaxBlocks + 1);

   localparam logic [26:0] HeapReset = 27'd33554432;
   localparam logic [26:0] HeapLimit = 27'd67108864;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOFIT   = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [26:0] request_size;
      logic [25:0] data_offset;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [25:0] result_offset;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        used;
      logic        tok;
      logic        seen;
      logic [25:0] start;
      logic [26:0] size;
   } cell_state_type;

   localparam int CellW = $bits(cell_state_type);

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_INIT,
      CMD_SCAN_START,
      CMD_SCAN_STEP,
      CMD_TAKE,
      CMD_SPLIT,
      CMD_MERGE_NEXT,
      CMD_MERGE_PREV,
      CMD_CLEAR_USED
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         op_free;
      logic         free_ok;
      logic [27:0]  need;
      logic [25:0]  find;
      logic [26:0]  size_a;
      logic [25:0]  start_b;
      logic [26:0]  size_b;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_FREE_A,
      S_FREE_B,
      S_RESP
   } ctl_state_type;

endpackage

### sv/ffha_cell.sv
// One block-table entry of the allocator chain with its search token.
module ffha_cell
   import ffha_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           head,
   input  cell_ctl_type   ctl,
   input  cell_state_type left_st,
   input  cell_state_type right_st,
   output cell_state_type st,
   output logic           match
);

   cell_state_type st_ff, st_in, rst_val;

   assign st = st_ff;

   assign match = st_ff.valid &
      (ctl.op_free ? (st_ff.used & ctl.free_ok & (st_ff.start == ctl.find))
                   : (!st_ff.used & ({1'b0, st_ff.size} >= ctl.need)));

   always_comb begin
      rst_val       = '0;
      rst_val.valid = head;
      rst_val.size  = head ? HeapReset : 27'd0;
   end

   always_comb begin
      st_in = st_ff;
      case (ctl.cmd)
         CMD_INIT: begin
            st_in       = '0;
            st_in.valid = head;
            st_in.size  = head ? ctl.size_a : 27'd0;
         end
         CMD_SCAN_START: begin
            st_in.tok  = head;
            st_in.seen = 1'b0;
         end
         CMD_SCAN_STEP: begin
            st_in.tok  = left_st.tok;
            st_in.seen = st_ff.seen | st_ff.tok;
         end
         CMD_TAKE: begin
            if (st_ff.tok) st_in.used = 1'b1;
         end
         CMD_SPLIT: begin
            if (st_ff.tok) begin
               st_in.used = 1'b1;
               st_in.size = ctl.size_a;
            end else if (left_st.tok) begin
               st_in.valid = 1'b1;
               st_in.used  = 1'b0;
               st_in.start = ctl.start_b;
               st_in.size  = ctl.size_b;
            end else if (!st_ff.seen) begin
               st_in.valid = left_st.valid;
               st_in.used  = left_st.used;
               st_in.start = left_st.start;
               st_in.size  = left_st.size;
            end
         end
         CMD_MERGE_NEXT: begin
            if (st_ff.tok) begin
               st_in.used = 1'b0;
               st_in.size = ctl.size_a;
            end else if (!st_ff.seen) begin
               st_in.valid = right_st.valid;
               st_in.used  = right_st.used;
               st_in.start = right_st.start;
               st_in.size  = right_st.size;
            end
         end
         CMD_MERGE_PREV: begin
            if (right_st.tok) begin
               st_in.size = ctl.size_a;
            end else if (st_ff.tok || !st_ff.seen) begin
               st_in.valid = right_st.valid;
               st_in.used  = right_st.used;
               st_in.start = right_st.start;
               st_in.size  = right_st.size;
            end
         end
         CMD_CLEAR_USED: begin
            if (st_ff.tok) st_in.used = 1'b0;
         end
         default: begin
            st_in = st_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rst_val;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

### sv/first_fit_heap_allocator_top.sv
// First-fit heap allocator: control sequencer over a chain of block-table cells.
//
//   Channel  Direction  Handshake                   Payload
//   req      in         req_valid / req_stall       req_type (opcode, size, offset)
//   rsp      out        rsp_valid / rsp_stall       rsp_type (status, offset)
//   csr      in/out     psel, penable, pready       heap size register at byte address 0
//
// Allocate and free pass a token along the cell chain, one cell per cycle, until
// a cell matches or the token leaves the valid blocks. Reset restores one free
// block of the reset heap size.
// A transaction waits in the output register while the next one is accepted;
// the sequencer holds its result while the output register is full and rsp_stall is high.
module first_fit_heap_allocator_top
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctl_state_type state_ff, state_in;
   cell_ctl_type  ctl;

   cell_state_type cst [MaxBlocks];
   cell_state_type lst [MaxBlocks];
   cell_state_type rst [MaxBlocks];
   logic [MaxBlocks-1:0] mt;

   logic [26:0] heap_ff;
   logic        op_free_ff, op_free_in;
   logic        free_ok_ff, free_ok_in;
   logic [27:0] need_ff, need_in;
   logic [25:0] find_ff, find_in;
   cell_state_type hit_ff, hit_in, nxt_ff, nxt_in, prv_ff, prv_in;
   logic [26:0] acc_ff, acc_in;
   logic [CountW-1:0] count_ff, count_in;
   status_type  res_st_ff, res_st_in;
   logic [25:0] res_off_ff, res_off_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept, hit_any, live, split, nxt_free, prv_free, load_rsp;
   logic [CellW-1:0] hit_v, nxt_v, prv_v;
   logic [26:0] first_block_size;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? 32'd0 : {5'd0, heap_ff};
   assign first_block_size = (heap_ff > HeapLimit) ? HeapLimit : heap_ff;

   genvar g;
   generate
      for (g = 0; g < MaxBlocks; g++) begin : g_cell
         if (g == 0) begin : g_l0
            assign lst[g] = '0;
         end else begin : g_l
            assign lst[g] = cst[g-1];
         end
         if (g == MaxBlocks - 1) begin : g_rn
            assign rst[g] = '0;
         end else begin : g_r
            assign rst[g] = cst[g+1];
         end
         ffha_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .head     (g == 0),
            .ctl      (ctl),
            .left_st  (lst[g]),
            .right_st (rst[g]),
            .st       (cst[g]),
            .match    (mt[g])
         );
      end
   endgenerate

   always_comb begin
      hit_any = 1'b0;
      live    = 1'b0;
      hit_v   = '0;
      nxt_v   = '0;
      prv_v   = '0;
      for (int j = 0; j < MaxBlocks; j++) begin
         hit_any = hit_any | (cst[j].tok & mt[j]);
         live    = live | (cst[j].tok & cst[j].valid);
         hit_v   = hit_v | (cst[j] & {CellW{cst[j].tok}});
         nxt_v   = nxt_v | (cst[j] & {CellW{lst[j].tok}});
         prv_v   = prv_v | (cst[j] & {CellW{rst[j].tok}});
      end
   end

   assign split = ({2'd0, hit_ff.size} > ({1'b0, need_ff} + 29'(HeaderBytes))) &&
                  (count_ff < CountW'(MaxBlocks));
   assign nxt_free = nxt_ff.valid & ~nxt_ff.used;
   assign prv_free = prv_ff.valid & ~prv_ff.used;
   assign load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_ALLOC: state_in = (req_data.request_size == 27'd0) ? S_RESP : S_SCAN;
                  OP_FREE:  state_in = S_SCAN;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (hit_any) begin
               state_in = op_free_ff ? S_FREE_A : S_ALLOC;
            end else if (!live) begin
               state_in = S_RESP;
            end
         end
         S_ALLOC:  state_in = S_RESP;
         S_FREE_A: state_in = S_FREE_B;
         S_FREE_B: state_in = S_RESP;
         S_RESP: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl         = '0;
      ctl.cmd     = CMD_NOP;
      ctl.op_free = op_free_ff;
      ctl.free_ok = free_ok_ff;
      ctl.need    = need_ff;
      ctl.find    = find_ff;
      op_free_in  = op_free_ff;
      free_ok_in  = free_ok_ff;
      need_in     = need_ff;
      find_in     = find_ff;
      hit_in      = hit_ff;
      nxt_in      = nxt_ff;
      prv_in      = prv_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      res_st_in   = res_st_ff;
      res_off_in  = res_off_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_st_in  = ST_OK;
               res_off_in = '0;
               need_in    = {1'b0, req_data.request_size} + 28'(HeaderBytes);
               find_in    = req_data.data_offset - 26'(HeaderBytes);
               free_ok_in = (req_data.data_offset >= 26'(HeaderBytes));
               op_free_in = (req_data.opcode == OP_FREE);
               case (req_data.opcode)
                  OP_INIT: begin
                     ctl.cmd    = CMD_INIT;
                     ctl.size_a = first_block_size;
                     count_in   = CountW'(1);
                  end
                  OP_ALLOC: begin
                     if (req_data.request_size == 27'd0) begin
                        res_st_in = ST_ZERO;
                     end else begin
                        ctl.cmd = CMD_SCAN_START;
                     end
                  end
                  OP_FREE: ctl.cmd = CMD_SCAN_START;
                  default: ctl.cmd = CMD_NOP;
               endcase
            end
         end
         S_SCAN: begin
            hit_in = hit_v;
            nxt_in = nxt_v;
            prv_in = prv_v;
            if (hit_any) begin
               ctl.cmd = CMD_NOP;
            end else if (!live) begin
               res_st_in = op_free_ff ? ST_BADFREE : ST_NOFIT;
            end else begin
               ctl.cmd = CMD_SCAN_STEP;
            end
         end
         S_ALLOC: begin
            res_off_in = hit_ff.start + 26'(HeaderBytes);
            if (split) begin
               ctl.cmd     = CMD_SPLIT;
               ctl.size_a  = need_ff[26:0];
               ctl.start_b = hit_ff.start + need_ff[25:0];
               ctl.size_b  = hit_ff.size - need_ff[26:0];
               count_in    = count_ff + CountW'(1);
            end else begin
               ctl.cmd = CMD_TAKE;
            end
         end
         S_FREE_A: begin
            if (nxt_free) begin
               ctl.cmd    = CMD_MERGE_NEXT;
               ctl.size_a = hit_ff.size + nxt_ff.size;
               acc_in     = hit_ff.size + nxt_ff.size;
               count_in   = count_ff - CountW'(1);
            end else begin
               ctl.cmd = CMD_CLEAR_USED;
               acc_in  = hit_ff.size;
            end
         end
         S_FREE_B: begin
            if (prv_free) begin
               ctl.cmd    = CMD_MERGE_PREV;
               ctl.size_a = prv_ff.size + acc_ff;
               count_in   = count_ff - CountW'(1);
            end
         end
         default: ctl.cmd = CMD_NOP;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = res_st_ff;
         rsp_data_in.result_offset = (res_st_ff == ST_OK) ? res_off_ff : 26'd0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CountW'(1);
         rsp_valid_ff <= 1'b0;
         heap_ff      <= HeapReset;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && !paddr[2]) begin
            heap_ff <= pwdata[26:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_free_ff  <= op_free_in;
      free_ok_ff  <= free_ok_in;
      need_ff     <= need_in;
      find_ff     <= find_in;
      hit_ff      <= hit_in;
      nxt_ff      <= nxt_in;
      prv_ff      <= prv_in;
      acc_ff      <= acc_in;
      res_st_ff   <= res_st_in;
      res_off_ff  <= res_off_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### tb/tb_first_fit_heap_allocator_top.sv
// Self-checking testbench for the first-fit heap allocator with a built-in block table predictor.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_top
   import ffha_pkg::*;
();

   localparam int WatchLimit = 20000;
   localparam int DrainCycles = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Predicted block table.
   logic [25:0] tbl_start [MaxBlocks];
   logic [26:0] tbl_size [MaxBlocks];
   bit          tbl_used [MaxBlocks];
   int          tbl_count;
   logic [26:0] heap_cfg;

   rsp_type     pending_rsp [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          rsp_taken = 0;
   int          rsp_wait = 0;
   bit          gaps_on = 1;

   first_fit_heap_allocator_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void table_init();
      logic [26:0] total;
      total = (heap_cfg > HeapLimit) ? HeapLimit : heap_cfg;
      for (int k = 0; k < MaxBlocks; k++) begin
         tbl_start[k] = '0;
         tbl_size[k] = '0;
         tbl_used[k] = 0;
      end
      tbl_size[0] = total;
      tbl_count = 1;
   endfunction

   function automatic void table_drop(int idx);
      for (int k = idx; k + 1 < tbl_count; k++) begin
         tbl_start[k] = tbl_start[k + 1];
         tbl_size[k] = tbl_size[k + 1];
         tbl_used[k] = tbl_used[k + 1];
      end
      tbl_count--;
      tbl_start[tbl_count] = '0;
      tbl_size[tbl_count] = '0;
      tbl_used[tbl_count] = 0;
   endfunction

   function automatic rsp_type table_alloc(logic [26:0] want);
      rsp_type r;
      longint sz, room, rq;
      r.status = ST_NOFIT;
      r.result_offset = '0;
      rq = longint'(want);
      if (want == 0) begin
         r.status = ST_ZERO;
         return r;
      end
      for (int i = 0; i < tbl_count; i++) begin
         sz = longint'(tbl_size[i]);
         if (tbl_used[i] || sz < HeaderBytes) continue;
         room = sz - HeaderBytes;
         if (room < rq) continue;
         if (room > rq + HeaderBytes && tbl_count < MaxBlocks) begin
            for (int k = tbl_count; k > i + 1; k--) begin
               tbl_start[k] = tbl_start[k - 1];
               tbl_size[k] = tbl_size[k - 1];
               tbl_used[k] = tbl_used[k - 1];
            end
            tbl_start[i + 1] = 26'(tbl_start[i] + rq + HeaderBytes);
            tbl_size[i + 1] = 27'(sz - (rq + HeaderBytes));
            tbl_used[i + 1] = 0;
            tbl_size[i] = 27'(rq + HeaderBytes);
            tbl_count++;
         end
         tbl_used[i] = 1;
         r.status = ST_OK;
         r.result_offset = 26'(tbl_start[i] + HeaderBytes);
         return r;
      end
      return r;
   endfunction

   function automatic status_type table_free(logic [25:0] off);
      int i;
      for (i = 0; i < tbl_count; i++)
         if (longint'(tbl_start[i]) + HeaderBytes == longint'(off) && tbl_used[i]) break;
      if (i >= tbl_count) return ST_BADFREE;
      tbl_used[i] = 0;
      if (i + 1 < tbl_count && !tbl_used[i + 1]) begin
         tbl_size[i] = tbl_size[i] + tbl_size[i + 1];
         table_drop(i + 1);
      end
      if (i > 0 && !tbl_used[i - 1]) begin
         tbl_size[i - 1] = tbl_size[i - 1] + tbl_size[i];
         table_drop(i);
      end
      return ST_OK;
   endfunction

   function automatic rsp_type heap_predict(req_type t);
      rsp_type r;
      r = '{status: ST_OK, result_offset: '0};
      case (t.opcode)
         OP_INIT: table_init();
         OP_ALLOC: r = table_alloc(t.request_size);
         OP_FREE: r.status = table_free(t.data_offset);
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_op(opcode_type op, logic [26:0] size, logic [25:0] off);
      int gap;
      req_type t;
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      t.opcode = op;
      t.request_size = size;
      t.data_offset = off;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = t;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(heap_predict(t));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_heap_size(logic [26:0] value);
      drain_results();
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = '0;
      pwdata = 32'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      heap_cfg = value;
   endtask

   function automatic logic [25:0] pick_used_offset();
      int n;
      int idx [$];
      for (int k = 0; k < tbl_count; k++) if (tbl_used[k]) idx.push_back(k);
      n = idx.size();
      if (n == 0) return 26'($urandom);
      return 26'(tbl_start[idx[$urandom_range(0, n - 1)]] + HeaderBytes);
   endfunction

   function automatic logic [26:0] pick_alloc_size(logic [26:0] span);
      int sel;
      int k;
      sel = $urandom_range(0, 99);
      if (sel < 15 && tbl_count > 0) begin
         k = $urandom_range(0, tbl_count - 1);
         if (tbl_size[k] >= HeaderBytes + 24)
            return 27'(tbl_size[k] - HeaderBytes - $urandom_range(0, 20));
      end
      if (sel < 20) return 27'($urandom);
      if (sel < 23) return '0;
      if (sel < 60) return 27'($urandom_range(1, 64));
      return 27'($urandom_range(1, (span > 8) ? span / 8 : 1));
   endfunction

   task automatic test_reset_state();
      send_op(OP_ALLOC, 27'd100, '0);
      send_op(OP_FREE, '0, 26'd16);
      send_op(OP_ALLOC, 27'd33554416, '0);
      send_op(OP_ALLOC, 27'd1, '0);
   endtask

   task automatic test_errors();
      send_op(OP_INIT, 27'h7FFFFFF, 26'h3FFFFFF);
      send_op(OP_ALLOC, '0, '0);
      send_op(OP_ALLOC, 27'h7FFFFFF, '0);
      send_op(OP_FREE, '0, 26'h3FFFFFF);
      send_op(OP_FREE, '0, 26'd16);
      send_op(OP_NONE, 27'h7FFFFFF, 26'h3FFFFFF);
   endtask

   task automatic test_split_and_merge();
      send_op(OP_ALLOC, 27'd32, '0);
      send_op(OP_ALLOC, 27'd48, '0);
      send_op(OP_ALLOC, 27'd64, '0);
      send_op(OP_FREE, '0, 26'd16);
      send_op(OP_FREE, '0, 26'd128);
      send_op(OP_FREE, '0, 26'd64);
   endtask

   task automatic test_tiny_heap();
      write_heap_size(27'd64);
      send_op(OP_INIT, '0, '0);
      send_op(OP_ALLOC, 27'd48, '0);
      send_op(OP_ALLOC, 27'd1, '0);
      send_op(OP_FREE, '0, 26'd16);
      send_op(OP_ALLOC, 27'd20, '0);
      send_op(OP_ALLOC, 27'd12, '0);
   endtask

   task automatic test_oversized_heap();
      write_heap_size(27'h7FFFFFF);
      send_op(OP_INIT, '0, '0);
      send_op(OP_ALLOC, 27'd67108848, '0);
      send_op(OP_FREE, '0, 26'd16);
   endtask

   task automatic test_full_table();
      write_heap_size(27'd4096);
      send_op(OP_INIT, '0, '0);
      for (int k = 0; k < MaxBlocks + 2; k++) send_op(OP_ALLOC, 27'd8, '0);
      for (int k = 0; k < 20; k++) send_op(OP_FREE, '0, pick_used_offset());
   endtask

   task automatic test_random_traffic(logic [26:0] heap, int count, bit hold_off);
      int sel;
      logic [26:0] span;
      write_heap_size(heap);
      span = (heap > HeapLimit) ? HeapLimit : heap;
      gaps_on = $urandom_range(0, 3) != 0;
      send_op(OP_INIT, 27'($urandom), 26'($urandom));
      for (int n = 0; n < count; n++) begin
         if (hold_off && n == count / 2) begin
            @(negedge clock);
            req_valid = 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         if (sel < 55) send_op(OP_ALLOC, pick_alloc_size(span), 26'($urandom));
         else if (sel < 88) send_op(OP_FREE, 27'($urandom), pick_used_offset());
         else if (sel < 95) send_op(OP_FREE, 27'($urandom), 26'($urandom));
         else if (sel < 98) send_op(OP_INIT, 27'($urandom), 26'($urandom));
         else send_op(OP_NONE, 27'($urandom), 26'($urandom));
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         rsp_taken = 1;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d/%0h",
                     $time, got.status, got.result_offset);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, got.status);
               fail_count++;
            end
            if (got.result_offset !== want.result_offset) begin
               $display("%0t: result_offset mismatch: expected %0h, actual %0h",
                        $time, want.result_offset, got.result_offset);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 0;
         rsp_wait = gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (rsp_wait > 0) begin
         rsp_stall = 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WatchLimit) begin
            $display("first_fit_heap_allocator_top test failed");
            $finish;
         end
      end
   end

   initial begin
      heap_cfg = HeapReset;
      table_init();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_errors();
      test_split_and_merge();
      test_tiny_heap();
      test_oversized_heap();
      test_full_table();
      test_random_traffic(27'd1024, 150, 0);
      test_random_traffic(27'd64, 60, 0);
      test_random_traffic(27'd4096, 200, 1);
      test_random_traffic(27'h7FFFFFF, 150, 0);
      test_random_traffic(27'(HeapLimit), 150, 0);
      test_random_traffic(27'($urandom_range(64, 67108864)), 150, 0);
      test_random_traffic(HeapReset, 100, 0);
      drain_results();
      if (fail_count == 0) begin
         $display("first_fit_heap_allocator_top test passed");
      end else begin
         $display("first_fit_heap_allocator_top test failed");
      end
      $finish;
   end

endmodule
